// ===== rtl/qlp_pkg.sv =====
// ----------------------------------------------------------------------------
// qlp_pkg: shared types and constants for the quoted list literal parser
// Holds the request and result payload structs, result kinds, parse states
// and the character codes that the parser recognizes.
// ----------------------------------------------------------------------------
`default_nettype none

package qlp_pkg;

  // One request: a byte of the literal or the end-of-string marker.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } item_t;

  // One result of the parser.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [9:0] element_length;
  } result_t;

  // Result kinds.
  typedef enum logic [2:0] {
    K_NONE   = 3'd0,
    K_CHAR   = 3'd1,
    K_END    = 3'd2,
    K_ACCEPT = 3'd3,
    K_BAD    = 3'd4,
    K_EARLY  = 3'd5
  } kind_t;

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_INNER  = 7'b0000010,
    ST_SQUOTE = 7'b0000100,
    ST_DQUOTE = 7'b0001000,
    ST_AFTER  = 7'b0010000,
    ST_COMMA  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  // Recognized character codes.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // A blank is a space or a tab.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qlp_core.sv =====
// ----------------------------------------------------------------------------
// qlp_core: parse state and per-byte decision logic
// Holds the parse phase, the element length counter and the abort flag, and
// works out the result for one request combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module qlp_core
  import qlp_pkg::*;
#(
  parameter int MAX_ELEMENT_LEN = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire item_t   item,
  output result_t      res
);

  localparam int CW = (MAX_ELEMENT_LEN > 2) ? $clog2(MAX_ELEMENT_LEN) : 1;
  localparam logic [CW-1:0] LIMIT = CW'(MAX_ELEMENT_LEN - 1);

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            aborted;
  logic            aborted_next;
  logic [7:0]      c;

  assign c = item.char_code;

  // Next state and result for the current request.
  always_comb begin
    state_next   = state;
    count_next   = count;
    aborted_next = aborted;
    res          = '0;
    res.kind     = K_NONE;
    if (item.end_of_string) begin
      if (aborted) begin
        res.kind = K_NONE;
      end else if (state == ST_DONE) begin
        res.kind = K_ACCEPT;
      end else begin
        res.kind = K_EARLY;
      end
      state_next   = ST_IDLE;
      count_next   = '0;
      aborted_next = 1'b0;
    end else if (!aborted) begin
      case (state)
        ST_IDLE: begin
          if (c == CH_LBRACE) begin
            state_next = ST_INNER;
          end else if (!is_blank(c)) begin
            res.kind     = K_BAD;
            aborted_next = 1'b1;
          end
        end
        ST_INNER, ST_COMMA: begin
          if (c == CH_SQUOTE) begin
            state_next = ST_SQUOTE;
            count_next = '0;
          end else if (c == CH_DQUOTE) begin
            state_next = ST_DQUOTE;
            count_next = '0;
          end else if (!is_blank(c)) begin
            res.kind     = K_BAD;
            aborted_next = 1'b1;
          end
        end
        ST_SQUOTE, ST_DQUOTE: begin
          if ((state == ST_SQUOTE && c == CH_SQUOTE) ||
              (state == ST_DQUOTE && c == CH_DQUOTE)) begin
            res.kind           = K_END;
            res.element_length = 10'(count);
            count_next         = '0;
            state_next         = ST_AFTER;
          end else if (count >= LIMIT) begin
            // The element buffer is full.
            res.kind     = K_BAD;
            aborted_next = 1'b1;
          end else begin
            res.kind     = K_CHAR;
            res.char_out = c;
            count_next   = count + 1'b1;
          end
        end
        ST_AFTER: begin
          if (c == CH_COMMA) begin
            state_next = ST_COMMA;
          end else if (c == CH_RBRACE) begin
            state_next = ST_DONE;
          end else if (!is_blank(c)) begin
            res.kind     = K_BAD;
            aborted_next = 1'b1;
          end
        end
        ST_DONE: begin
          if (!is_blank(c)) begin
            res.kind     = K_BAD;
            aborted_next = 1'b1;
          end
        end
        default: begin
          res.kind     = K_BAD;
          aborted_next = 1'b1;
        end
      endcase
    end
  end

  // State registers advance only when a request is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      aborted <= 1'b0;
    end else if (fire) begin
      state   <= state_next;
      count   <= count_next;
      aborted <= aborted_next;
    end
  end

`ifndef SYNTHESIS
  // The end marker always returns the parser to its reset condition.
  a_eos_restart: assert property (@(posedge clk) disable iff (rst)
    fire && item.end_of_string |=> state == ST_IDLE && !aborted && count == '0)
    else $error("parser did not restart after end marker");

  // Once aborted, ordinary bytes produce nothing.
  a_abort_quiet: assert property (@(posedge clk) disable iff (rst)
    fire && aborted && !item.end_of_string |-> res.kind == K_NONE)
    else $error("result produced while aborted");

  // Each emitted element character grows the length by one.
  a_char_count: assert property (@(posedge clk) disable iff (rst)
    fire && res.kind == K_CHAR |=> count == $past(count) + 1'b1)
    else $error("element length did not track characters");

  // The element length never passes the buffer limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= LIMIT)
    else $error("element length beyond limit");
`endif

endmodule

`default_nettype wire

// ===== rtl/quoted_list_literal_parser.sv =====
// ----------------------------------------------------------------------------
// quoted_list_literal_parser: streaming parser for quoted list literals
// Accepts one byte or end marker per request and returns one result per
// request: element characters, element ends with length, verdicts, or K_NONE.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on item_valid / item_stall / item, one byte of the
//   literal or the end-of-string marker each. Every request yields exactly one
//   result on result_valid / result_stall / result, in order.
//   A request is registered on acceptance; when the result register is free
//   or draining, the parse logic updates its state and loads the result
//   register from the held request. One request is taken every cycle while
//   results drain; the core decides each request combinationally, which
//   sets that rate.
//   When the receiver stalls, the result register holds its value and the
//   input register fills; item_stall then rises until the result is taken.
//   Reset (rst, synchronous) empties both registers and returns the parser
//   to the opening phase with a cleared length and abort flag.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_list_literal_parser
  import qlp_pkg::*;
#(
  parameter int MAX_ELEMENT_LEN = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic    held_valid;
  item_t   held;
  logic    advance;
  result_t core_res;

  // The held request moves on when the result register is free or draining.
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  qlp_core #(
    .MAX_ELEMENT_LEN(MAX_ELEMENT_LEN)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (held),
    .res  (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_res;
    end
  end

endmodule

`default_nettype wire
